// ----- src/bvdm_pkg.sv -----
package bvdm_pkg;

   localparam int unsigned LEVEL_W  = 15;
   localparam int unsigned GAIN_W   = 16;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned CSR_IX_W = 3;
   localparam int unsigned CSR_D_W  = 32;

   localparam int unsigned ROUND_BIAS = 32768;

   localparam logic [LEVEL_W-1:0] LOW_THRESHOLD_RST   = LEVEL_W'(3300);
   localparam logic [GAIN_W-1:0]  FILTER_GAIN_RST     = GAIN_W'(6554);
   localparam logic [TIME_W-1:0]  ALARM_REPEAT_RST    = TIME_W'(10000);
   localparam logic [TIME_W-1:0]  LOW_ASSERT_RST      = TIME_W'(5000);
   localparam logic [LEVEL_W-1:0] CLEAR_MARGIN_RST    = LEVEL_W'(200);
   localparam logic [TIME_W-1:0]  CLEAR_HOLD_RST      = TIME_W'(5000);

   typedef enum logic [CSR_IX_W-1:0] {
      CSR_LOW_THRESHOLD = 3'd0,
      CSR_FILTER_GAIN   = 3'd1,
      CSR_ALARM_REPEAT  = 3'd2,
      CSR_LOW_ASSERT    = 3'd3,
      CSR_CLEAR_MARGIN  = 3'd4,
      CSR_CLEAR_HOLD    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] low_limit_mv;
      logic [GAIN_W-1:0]  filter_gain;
      logic [TIME_W-1:0]  alarm_repeat_ms;
      logic [TIME_W-1:0]  low_assert_ms;
      logic [LEVEL_W-1:0] clear_margin_mv;
      logic [TIME_W-1:0]  clear_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic              level_valid;
      logic [TIME_W-1:0] time_ms;
      logic [TIME_W-1:0] elapsed;
   } item_type;

endpackage

// ----- src/bvdm_filter.sv -----
module bvdm_filter #(
   parameter int unsigned FRAC_BITS = 16,
   parameter int unsigned MAX_MV    = 20000
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      load,
   input  logic [bvdm_pkg::GAIN_W-1:0]               filter_gain,
   input  logic [15:0]                               raw_mv,
   input  logic                                      ref_ok,
   input  logic [bvdm_pkg::TIME_W-1:0]               time_ms,
   output logic [$clog2(MAX_MV+1)+FRAC_BITS-1:0]     level_fix,
   output bvdm_pkg::item_type                        item
);

   localparam int unsigned LVL_W  = $clog2(MAX_MV + 1);
   localparam int unsigned F_W    = LVL_W + FRAC_BITS;
   localparam int unsigned PROD_W = F_W + bvdm_pkg::GAIN_W + 2;

   logic [F_W-1:0]                   f_ff, f_in;
   logic                             seeded_ff, seeded_in;
   logic [bvdm_pkg::TIME_W-1:0]      prev_time_ff;
   logic                             prev_valid_ff;
   bvdm_pkg::item_type               item_ff, item_in;

   logic                             sample_ok;
   logic [F_W-1:0]                   target;
   logic signed [F_W:0]              diff_s;
   logic signed [PROD_W-1:0]         prod_s;
   logic signed [PROD_W-1:0]         bias_s;
   logic signed [PROD_W-1:0]         shift_s;
   logic signed [F_W:0]              delta_s;
   logic signed [F_W:0]              sum_s;

   assign sample_ok = ref_ok && (raw_mv != 16'd0) && (raw_mv <= 16'(MAX_MV));
   assign target    = {raw_mv[LVL_W-1:0], {FRAC_BITS{1'b0}}};
   assign diff_s    = $signed({1'b0, target}) - $signed({1'b0, f_ff});
   assign prod_s    = $signed({1'b0, filter_gain}) * diff_s;
   assign bias_s    = $signed(PROD_W'(bvdm_pkg::ROUND_BIAS));
   assign shift_s   = (prod_s + bias_s) >>> bvdm_pkg::GAIN_W;
   assign delta_s   = shift_s[F_W:0];
   assign sum_s     = $signed({1'b0, f_ff}) + delta_s;

   always_comb begin
      f_in      = f_ff;
      seeded_in = seeded_ff;
      if (sample_ok) begin
         if (!seeded_ff) begin
            f_in      = target;
            seeded_in = 1'b1;
         end else begin
            f_in = sum_s[F_W-1:0];
         end
      end
      item_in.level_valid = sample_ok;
      item_in.time_ms     = time_ms;
      item_in.elapsed     = (sample_ok && prev_valid_ff) ? (time_ms - prev_time_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ff          <= '0;
         seeded_ff     <= 1'b0;
         prev_time_ff  <= '0;
         prev_valid_ff <= 1'b0;
      end else if (load) begin
         f_ff          <= f_in;
         seeded_ff     <= seeded_in;
         prev_time_ff  <= time_ms;
         prev_valid_ff <= sample_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign level_fix = f_ff;
   assign item      = item_ff;

endmodule

// ----- src/bvdm_debounce.sv -----
module bvdm_debounce #(
   parameter int unsigned FRAC_BITS = 16,
   parameter int unsigned MAX_MV    = 20000
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic                                  tracker_clear,
   input  bvdm_pkg::cfg_type                     cfg,
   input  bvdm_pkg::item_type                    item,
   input  logic [$clog2(MAX_MV+1)+FRAC_BITS-1:0] level_fix,
   output logic                                  level_valid,
   output logic [bvdm_pkg::LEVEL_W-1:0]          level_mv,
   output logic                                  is_low,
   output logic                                  alarm_request
);

   localparam int unsigned LVL_W = $clog2(MAX_MV + 1);
   localparam int unsigned F_W   = LVL_W + FRAC_BITS;
   localparam int unsigned CMP_W = 17;
   localparam int unsigned TW    = bvdm_pkg::TIME_W;

   logic                         low_ff, low_in;
   logic                         fired_ff, fired_in;
   logic [TW-1:0]                last_ff, last_in;
   logic                         lt_ff, lt_in;
   logic [TW-1:0]                le_ff, le_in;
   logic                         ct_ff, ct_in;
   logic [TW-1:0]                ce_ff, ce_in;
   logic                         alarm_c;

   logic                         valid_ff;
   logic [bvdm_pkg::LEVEL_W-1:0] level_ff;
   logic                         is_low_ff;
   logic                         alarm_ff;

   logic [F_W:0]                 rounded;
   logic [LVL_W:0]               whole;
   logic [LVL_W-1:0]             level;
   logic [CMP_W-1:0]             level_x;
   logic [CMP_W-1:0]             thr_x;
   logic [CMP_W-1:0]             clear_sum;
   logic [CMP_W-1:0]             clear_lvl;
   logic [TW:0]                  low_sum;
   logic [TW:0]                  clear_sum_t;
   logic [TW-1:0]                low_sat;
   logic [TW-1:0]                clear_sat;
   logic [TW-1:0]                since_alarm;

   assign rounded = (F_W+1)'(level_fix) + ((F_W+1)'(1) << (FRAC_BITS - 1));
   assign whole   = rounded[F_W:FRAC_BITS];
   assign level   = (whole > (LVL_W+1)'(MAX_MV)) ? LVL_W'(MAX_MV) : whole[LVL_W-1:0];
   assign level_x = CMP_W'(level);
   assign thr_x   = CMP_W'(cfg.low_limit_mv);

   assign clear_sum = CMP_W'(cfg.low_limit_mv) + CMP_W'(cfg.clear_margin_mv);
   assign clear_lvl = (clear_sum > CMP_W'(MAX_MV)) ? CMP_W'(MAX_MV) : clear_sum;

   assign low_sum     = {1'b0, le_ff} + {1'b0, item.elapsed};
   assign clear_sum_t = {1'b0, ce_ff} + {1'b0, item.elapsed};
   assign low_sat     = low_sum[TW] ? '1 : low_sum[TW-1:0];
   assign clear_sat   = clear_sum_t[TW] ? '1 : clear_sum_t[TW-1:0];
   assign since_alarm = item.time_ms - last_ff;

   always_comb begin
      alarm_c  = 1'b0;
      low_in   = low_ff;
      fired_in = fired_ff;
      last_in  = last_ff;
      lt_in    = lt_ff;
      le_in    = le_ff;
      ct_in    = ct_ff;
      ce_in    = ce_ff;
      if (low_ff && fired_ff && (since_alarm >= cfg.alarm_repeat_ms)) begin
         alarm_c = 1'b1;
         last_in = item.time_ms;
      end
      if (item.level_valid) begin
         if (!low_ff) begin
            ct_in = 1'b0;
            ce_in = '0;
            if (level_x >= thr_x) begin
               lt_in = 1'b0;
               le_in = '0;
            end else begin
               lt_in = 1'b1;
               le_in = lt_ff ? low_sat : '0;
               if (le_in >= cfg.low_assert_ms) begin
                  low_in   = 1'b1;
                  lt_in    = 1'b0;
                  le_in    = '0;
                  fired_in = 1'b1;
                  last_in  = item.time_ms;
                  alarm_c  = 1'b1;
               end
            end
         end else begin
            lt_in = 1'b0;
            le_in = '0;
            if (level_x < clear_lvl) begin
               ct_in = 1'b0;
               ce_in = '0;
            end else begin
               ct_in = 1'b1;
               ce_in = ct_ff ? clear_sat : '0;
               if (ce_in >= cfg.clear_hold_ms) begin
                  low_in   = 1'b0;
                  ct_in    = 1'b0;
                  ce_in    = '0;
                  fired_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff   <= 1'b0;
         fired_ff <= 1'b0;
         last_ff  <= '0;
         lt_ff    <= 1'b0;
         le_ff    <= '0;
         ct_ff    <= 1'b0;
         ce_ff    <= '0;
      end else if (tracker_clear) begin
         lt_ff <= 1'b0;
         le_ff <= '0;
         ct_ff <= 1'b0;
         ce_ff <= '0;
      end else if (load) begin
         low_ff   <= low_in;
         fired_ff <= fired_in;
         last_ff  <= last_in;
         lt_ff    <= lt_in;
         le_ff    <= le_in;
         ct_ff    <= ct_in;
         ce_ff    <= ce_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         valid_ff  <= item.level_valid;
         level_ff  <= item.level_valid ? bvdm_pkg::LEVEL_W'(level) : '0;
         is_low_ff <= low_in;
         alarm_ff  <= alarm_c;
      end
   end

   assign level_valid   = valid_ff;
   assign level_mv      = level_ff;
   assign is_low        = is_low_ff;
   assign alarm_request = alarm_ff;

`ifndef ASSERT_OFF
   a_trackers_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(lt_ff && ct_ff))
      else $error("low and clear trackers active together");

   a_fired_follows_low : assert property (@(posedge clock) disable iff (reset)
      fired_ff == low_ff)
      else $error("alarm fired flag out of step with low state");

   a_threshold_clears : assert property (@(posedge clock) disable iff (reset)
      tracker_clear |=> (!lt_ff && !ct_ff && le_ff == '0 && ce_ff == '0))
      else $error("threshold write left a tracker running");

   a_low_only_on_beat : assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(low_ff))
      else $error("low state moved without a beat");
`endif

endmodule

// ----- src/battery_voltage_debounce_monitor.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    raw_mv, ref_ok, time_ms
// rsp      out        rsp_valid/rsp_ready    level_valid, level_mv, is_low, alarm_request
// csr      in         csr_valid/csr_ready    index, wdata (always ready)
//
// One beat is taken per cycle while rsp_ready is high; results pass three register stages.
// The filter update (one multiply and add) and the debounce step each take one register stage.
// Reset clears valid, filter and debounce state and loads register defaults; no clearing pass.
// When rsp_ready is low the three stages fill and then req_ready drops.
module battery_voltage_debounce_monitor #(
   parameter int unsigned FRAC_BITS = 16,
   parameter int unsigned MAX_MV    = 20000
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [15:0]                         req_raw_mv,
   input  logic                                req_ref_ok,
   input  logic [bvdm_pkg::TIME_W-1:0]         req_time_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_level_valid,
   output logic [bvdm_pkg::LEVEL_W-1:0]        rsp_level_mv,
   output logic                                rsp_is_low,
   output logic                                rsp_alarm_request,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bvdm_pkg::CSR_IX_W-1:0]       csr_index,
   input  logic [bvdm_pkg::CSR_D_W-1:0]        csr_wdata
);

   localparam int unsigned LVL_W = $clog2(MAX_MV + 1);
   localparam int unsigned F_W   = LVL_W + FRAC_BITS;

   bvdm_pkg::cfg_type              cfg_ff;
   logic                           s1_valid_ff, s1_valid_in;
   logic                           s2_valid_ff, s2_valid_in;
   logic                           out_valid_ff, out_valid_in;
   logic [15:0]                    raw_ff;
   logic                           ref_ff;
   logic [bvdm_pkg::TIME_W-1:0]    time_ff;

   logic                           out_free;
   logic                           s2_free;
   logic                           s2_move;
   logic                           s1_move;
   logic                           req_take;
   logic                           csr_take;
   logic                           thr_change;
   logic [F_W-1:0]                 level_fix;
   bvdm_pkg::item_type             item;

   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;
   assign thr_change = csr_take && (csr_index == bvdm_pkg::CSR_LOW_THRESHOLD)
                       && (csr_wdata[bvdm_pkg::LEVEL_W-1:0] != cfg_ff.low_limit_mv);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_limit_mv     <= bvdm_pkg::LOW_THRESHOLD_RST;
         cfg_ff.filter_gain      <= bvdm_pkg::FILTER_GAIN_RST;
         cfg_ff.alarm_repeat_ms  <= bvdm_pkg::ALARM_REPEAT_RST;
         cfg_ff.low_assert_ms    <= bvdm_pkg::LOW_ASSERT_RST;
         cfg_ff.clear_margin_mv  <= bvdm_pkg::CLEAR_MARGIN_RST;
         cfg_ff.clear_hold_ms    <= bvdm_pkg::CLEAR_HOLD_RST;
      end else if (csr_take) begin
         unique case (csr_index)
            bvdm_pkg::CSR_LOW_THRESHOLD:
               cfg_ff.low_limit_mv <= csr_wdata[bvdm_pkg::LEVEL_W-1:0];
            bvdm_pkg::CSR_FILTER_GAIN:
               cfg_ff.filter_gain <= csr_wdata[bvdm_pkg::GAIN_W-1:0];
            bvdm_pkg::CSR_ALARM_REPEAT:
               cfg_ff.alarm_repeat_ms <= csr_wdata[bvdm_pkg::TIME_W-1:0];
            bvdm_pkg::CSR_LOW_ASSERT:
               cfg_ff.low_assert_ms <= csr_wdata[bvdm_pkg::TIME_W-1:0];
            bvdm_pkg::CSR_CLEAR_MARGIN:
               cfg_ff.clear_margin_mv <= csr_wdata[bvdm_pkg::LEVEL_W-1:0];
            bvdm_pkg::CSR_CLEAR_HOLD:
               cfg_ff.clear_hold_ms <= csr_wdata[bvdm_pkg::TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s2_move   = s2_valid_ff && out_free;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
      out_valid_in = s2_move ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         raw_ff  <= req_raw_mv;
         ref_ff  <= req_ref_ok;
         time_ff <= req_time_ms;
      end
   end

   bvdm_filter #(
      .FRAC_BITS (FRAC_BITS),
      .MAX_MV    (MAX_MV)
   ) u_filter (
      .clock       (clock),
      .reset       (reset),
      .load        (s1_move),
      .filter_gain (cfg_ff.filter_gain),
      .raw_mv      (raw_ff),
      .ref_ok      (ref_ff),
      .time_ms     (time_ff),
      .level_fix   (level_fix),
      .item        (item)
   );

   bvdm_debounce #(
      .FRAC_BITS (FRAC_BITS),
      .MAX_MV    (MAX_MV)
   ) u_debounce (
      .clock         (clock),
      .reset         (reset),
      .load          (s2_move),
      .tracker_clear (thr_change),
      .cfg           (cfg_ff),
      .item          (item),
      .level_fix     (level_fix),
      .level_valid   (rsp_level_valid),
      .level_mv      (rsp_level_mv),
      .is_low        (rsp_is_low),
      .alarm_request (rsp_alarm_request)
   );

   assign rsp_valid = out_valid_ff;

endmodule
